// ----- hw/rtl/hds_pkg.sv -----
// Shared types and constants for the heat diffusion stencil step.
// Used by the front end, the job queue, the arithmetic back end and the top level.
package hds_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int IDX_W      = 10;
  localparam int COEF_W     = 16;
  localparam int DIM_W      = 11;
  localparam int MIN_DIM    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 56;
  localparam int M_PAD_W    = M_TDATA_W - SAMPLE_W - 2 * IDX_W;
  localparam int Q_DEPTH    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [IDX_W-1:0]           idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } dims_t;

  typedef struct packed {
    logic [COEF_W-1:0] cx;
    logic [COEF_W-1:0] cy;
  } coefs_t;

  typedef struct packed {
    logic full;
    logic nearly_full;
  } q_status_t;

  // One stencil job: neighbourhood, positions and what to emit.
  typedef struct packed {
    sample_t ctr;
    sample_t north;
    sample_t south;
    sample_t west;
    sample_t east;
    idx_t    orow;
    idx_t    lrow;
    idx_t    col;
    logic    emit_main;
    logic    border;
    logic    emit_last;
    logic    frame_end;
  } job_t;

  typedef struct packed {
    sample_t value;
    idx_t    row;
    idx_t    col;
    logic    last;
  } result_t;

endpackage

// ----- hw/rtl/hds_front.sv -----
// Front end: position counters, the two line stores and job classification.
// Depends on hds_pkg; feeds hds_queue.
module hds_front import hds_pkg::*; #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sample_t   in_sample,
  input  logic      in_frame_start,
  input  dims_t     dims,
  input  q_status_t q_stat,
  output logic      push,
  output job_t      push_job
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  logic [RW-1:0] row_cnt;
  logic [CW-1:0] col_cnt;
  logic [RW:0]   rows;
  logic [CW:0]   cols;
  logic [RW-1:0] rows_m1, r, orow;
  logic [CW-1:0] cols_m1, c, east_addr;
  logic          accept, col_last, row_last;
  logic          border, emit_main, emit_last, fend;

  sample_t prior_mem [MAX_COLS];
  sample_t older_mem [MAX_COLS];
  sample_t ctr_rd, east_rd, north_rd, west;

  logic          f1_valid;
  logic [CW-1:0] f1_col;
  sample_t       f1_south;
  idx_t          f1_orow, f1_lrow, f1_idx_col;
  logic          f1_emit_main, f1_border, f1_emit_last, f1_fend;

  // Clamp the grid size between the minimum and what the line stores can hold
  always_comb begin
    if (dims.rows < DIM_W'(MIN_DIM)) rows = (RW+1)'(MIN_DIM);
    else if (32'(dims.rows) > MAX_ROWS) rows = (RW+1)'(MAX_ROWS);
    else rows = (RW+1)'(dims.rows);
    if (dims.cols < DIM_W'(MIN_DIM)) cols = (CW+1)'(MIN_DIM);
    else if (32'(dims.cols) > MAX_COLS) cols = (CW+1)'(MAX_COLS);
    else cols = (CW+1)'(dims.cols);
  end

  assign rows_m1   = RW'(rows - 1'b1);
  assign cols_m1   = CW'(cols - 1'b1);
  assign r         = in_frame_start ? '0 : row_cnt;
  assign c         = in_frame_start ? '0 : col_cnt;
  assign orow      = r - 1'b1;
  assign east_addr = (c == CW'(MAX_COLS - 1)) ? '0 : c + 1'b1;

  assign emit_main = (r != '0);
  assign emit_last = (r == rows_m1);
  assign fend      = (c == cols_m1);
  assign border    = (orow == '0) || (orow >= rows_m1) || (c == '0) || (c >= cols_m1);
  assign col_last  = (c >= cols_m1);
  assign row_last  = (r >= rows_m1);

  // Reserve a queue slot for the job already in flight
  assign in_ready = f1_valid ? !q_stat.nearly_full : !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt  <= '0;
      col_cnt  <= '0;
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
      if (accept) begin
        if (col_last) begin
          col_cnt <= '0;
          row_cnt <= row_last ? '0 : r + 1'b1;
        end else begin
          col_cnt <= c + 1'b1;
          row_cnt <= r;
        end
      end
    end
  end

  // Row above: read old contents, then overwrite with the new sample
  always_ff @(posedge clk) begin
    if (accept) begin
      prior_mem[c] <= in_sample;
      ctr_rd       <= prior_mem[c];
      east_rd      <= prior_mem[east_addr];
    end
  end

  // Row two above: written from the registered row-above read, so forward the pending word
  always_ff @(posedge clk) begin
    if (f1_valid) older_mem[f1_col] <= ctr_rd;
    if (accept) north_rd <= (f1_valid && (f1_col == c)) ? ctr_rd : older_mem[c];
  end

  always_ff @(posedge clk) begin
    if (f1_valid) west <= ctr_rd;
    if (accept) begin
      f1_col       <= c;
      f1_south     <= in_sample;
      f1_orow      <= IDX_W'(orow);
      f1_lrow      <= IDX_W'(r);
      f1_idx_col   <= IDX_W'(c);
      f1_emit_main <= emit_main;
      f1_border    <= border;
      f1_emit_last <= emit_last;
      f1_fend      <= fend;
    end
  end

  // Drop jobs that produce no result (first row)
  assign push = f1_valid && (f1_emit_main || f1_emit_last);

  always_comb begin
    push_job.ctr       = ctr_rd;
    push_job.north     = north_rd;
    push_job.south     = f1_south;
    push_job.west      = west;
    push_job.east      = east_rd;
    push_job.orow      = f1_orow;
    push_job.lrow      = f1_lrow;
    push_job.col       = f1_idx_col;
    push_job.emit_main = f1_emit_main;
    push_job.border    = f1_border;
    push_job.emit_last = f1_emit_last;
    push_job.frame_end = f1_fend;
  end

endmodule

// ----- hw/rtl/hds_queue.sv -----
// Short job queue between the front end and the arithmetic back end.
// Depends on hds_pkg.
module hds_queue import hds_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output logic      head_valid,
  output job_t      head_job,
  output q_status_t stat
);

  localparam int PW = $clog2(Q_DEPTH);

  job_t        entries [Q_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          do_pop;

  assign head_valid       = (count != '0);
  assign head_job         = entries[rd_ptr];
  assign do_pop           = pop && head_valid;
  assign stat.full        = (count == (PW+1)'(Q_DEPTH));
  assign stat.nearly_full = (count >= (PW+1)'(Q_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

endmodule

// ----- hw/rtl/hds_back.sv -----
// Back end: stencil arithmetic in three stages, rounding, saturation and
// result sequencing into the output register. Depends on hds_pkg.
module hds_back import hds_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  coefs_t  coefs,
  input  logic    q_valid,
  input  job_t    q_job,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  localparam int DIFF_W = SAMPLE_W + 2;
  localparam int PROD_W = DIFF_W + COEF_W + 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam int HI_W   = ACC_W - SAMPLE_W + 1;

  logic                     s1_valid, s2_valid, s3_valid;
  job_t                     s1_job, s2_job;
  logic signed [DIFF_W-1:0] s1_dv, s1_dh, dv, dh, ctr2;
  logic signed [PROD_W-1:0] s2_pv, s2_ph;
  logic signed [ACC_W-1:0]  acc, quo;
  logic [HI_W-1:0]          quo_hi;
  sample_t                  sat, main_value;

  logic    s3_main_pend, s3_last_pend, s3_fend;
  sample_t s3_main_value, s3_copy_value;
  idx_t    s3_orow, s3_lrow, s3_col;

  logic o_free, emit_now, s3_done, s3_free, s2_free, s1_free;

  // Stall chain from the output register back to the queue
  assign o_free   = !out_valid || out_ready;
  assign emit_now = s3_valid && o_free;
  assign s3_done  = emit_now && !(s3_main_pend && s3_last_pend);
  assign s3_free  = !s3_valid || s3_done;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign pop      = q_valid && s1_free;

  // Stage 1: second differences
  always_comb begin
    ctr2 = DIFF_W'($signed(q_job.ctr)) <<< 1;
    dv   = DIFF_W'($signed(q_job.north)) + DIFF_W'($signed(q_job.south)) - ctr2;
    dh   = DIFF_W'($signed(q_job.west)) + DIFF_W'($signed(q_job.east)) - ctr2;
  end

  // Stage 3 input: weighted sum, round half up, saturate; border jobs keep the centre value
  always_comb begin
    acc = (ACC_W'($signed(s2_job.ctr)) <<< COEF_W) + ACC_W'(s2_pv) + ACC_W'(s2_ph)
          + ACC_W'(1 << (COEF_W - 1));
    quo    = acc >>> COEF_W;
    quo_hi = quo[ACC_W-1:SAMPLE_W-1];
    if ((&quo_hi) || !(|quo_hi)) sat = quo[SAMPLE_W-1:0];
    else if (quo[ACC_W-1]) sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    else sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    main_value = s2_job.border ? s2_job.ctr : sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= q_valid;
      if (s2_free) s2_valid <= s1_valid;
      if (s3_free) s3_valid <= s2_valid;
      if (emit_now) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_job <= q_job;
      s1_dv  <= dv;
      s1_dh  <= dh;
    end
    if (s2_free) begin
      s2_job <= s1_job;
      s2_pv  <= $signed({1'b0, coefs.cx}) * s1_dv;
      s2_ph  <= $signed({1'b0, coefs.cy}) * s1_dh;
    end
    if (s3_free) begin
      s3_main_pend  <= s2_job.emit_main;
      s3_last_pend  <= s2_job.emit_last;
      s3_main_value <= main_value;
      s3_copy_value <= s2_job.south;
      s3_orow       <= s2_job.orow;
      s3_lrow       <= s2_job.lrow;
      s3_col        <= s2_job.col;
      s3_fend       <= s2_job.frame_end;
    end else if (emit_now) begin
      s3_main_pend <= 1'b0;
    end
    // Updated value of the row above goes first, then the last-row copy
    if (emit_now) begin
      if (s3_main_pend) begin
        out_res.value <= s3_main_value;
        out_res.row   <= s3_orow;
        out_res.last  <= 1'b0;
      end else begin
        out_res.value <= s3_copy_value;
        out_res.row   <= s3_lrow;
        out_res.last  <= s3_fend;
      end
      out_res.col <= s3_col;
    end
  end

endmodule

// ----- hw/rtl/heat_diffusion_stencil_step_top.sv -----
// Top level of the heat diffusion stencil step: configuration registers and
// the front end, job queue and back end. Depends on hds_pkg and those modules.
//
//  channel  direction  handshake              payload
//  s_*      in         s_tvalid / s_tready    s_tdata: sample; s_tuser: frame_start
//  m_*      out        m_tvalid / m_tready    m_tdata: value, row_index, col_index;
//                                             m_tlast: frame_end
//  cfg_*    in         cfg_we                 cfg_index, cfg_data
//
// One sample is accepted per cycle while the job queue has room; one result leaves
// per cycle through the output register while m_tready is high, so on the last row
// (two results per sample) the output port sets the pace once the four-entry queue
// fills. From acceptance to its first result a sample passes the line store read,
// the queue, three arithmetic stages and the output register.
// Reset (rst, synchronous) clears counters, queue and valid flags; the line
// stores are not cleared. Either side may stall without losing a transaction.
module heat_diffusion_stencil_step_top import hds_pkg::*; #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] sample
  input  logic [0:0]            s_tuser,   // [0] frame_start
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] value, [41:32] row_index,
                                           // [51:42] col_index, [55:52] zero
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  coefs_t    coefs;
  dims_t     dims;
  q_status_t q_stat;
  logic      push, pop, q_valid;
  job_t      push_job, q_job;
  result_t   res;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.cx  <= COEF_W'(6554);
      coefs.cy  <= COEF_W'(6554);
      dims.rows <= DIM_W'(100);
      dims.cols <= DIM_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_X:    coefs.cx  <= cfg_data[COEF_W-1:0];
        REG_COEF_Y:    coefs.cy  <= cfg_data[COEF_W-1:0];
        REG_GRID_ROWS: dims.rows <= cfg_data[DIM_W-1:0];
        REG_GRID_COLS: dims.cols <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  hds_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_sample      ($signed(s_tdata[SAMPLE_W-1:0])),
    .in_frame_start (s_tuser[0]),
    .dims           (dims),
    .q_stat         (q_stat),
    .push           (push),
    .push_job       (push_job)
  );

  hds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (q_valid),
    .head_job   (q_job),
    .stat       (q_stat)
  );

  hds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .coefs     (coefs),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {M_PAD_W'(0), res.col, res.row, res.value};
  assign m_tlast = res.last;

endmodule

// ----- tb/tb_heat_diffusion_stencil_step_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for heat_diffusion_stencil_step_top: drives grids through
// the sample stream and checks every result against an in-bench stencil predictor.
// Depends on hds_pkg and the top level only.

module tb_heat_diffusion_stencil_step_top;
  import hds_pkg::*;

  localparam int GRID_MAX      = 1024;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 400;
  localparam longint SAT_HI    = 64'sd2147483647;
  localparam longint SAT_LO    = -64'sd2147483648;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  // Predicts the stencil results and holds the ones still due from the block.
  class stencil_scoreboard;
    logic [COEF_W-1:0] cx, cy;
    logic [DIM_W-1:0]  rows_reg, cols_reg;
    sample_t           row_above [GRID_MAX];
    sample_t           row_last [GRID_MAX];
    sample_t           west;
    int unsigned       row_pos, col_pos;
    result_t           due_results[$];
    int                errors;

    function new();
      cx       = 16'd6554;
      cy       = 16'd6554;
      rows_reg = 11'd100;
      cols_reg = 11'd100;
      foreach (row_above[i]) begin
        row_above[i] = '0;
        row_last[i]  = '0;
      end
      west    = '0;
      row_pos = 0;
      col_pos = 0;
      errors  = 0;
    endfunction

    function int unsigned clamp_dim(logic [DIM_W-1:0] v);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > GRID_MAX) return GRID_MAX;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_COEF_X:    cx = data;
        REG_COEF_Y:    cy = data;
        REG_GRID_ROWS: rows_reg = data[DIM_W-1:0];
        REG_GRID_COLS: cols_reg = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function sample_t diffuse_point(sample_t u, sample_t n, sample_t s, sample_t w,
                                    sample_t e);
      longint d_vert, d_horz, acc, q;
      d_vert = longint'(n) + longint'(s) - 2 * longint'(u);
      d_horz = longint'(w) + longint'(e) - 2 * longint'(u);
      acc    = longint'(u) * 65536 + longint'(cx) * d_vert + longint'(cy) * d_horz;
      // round half up, then saturate to the sample range
      q = (acc + 32768) >>> 16;
      if (q > SAT_HI) q = SAT_HI;
      if (q < SAT_LO) q = SAT_LO;
      return sample_t'(q);
    endfunction

    function void take_sample(sample_t s, logic frame_start);
      int unsigned rows, cols, r, c, orow;
      sample_t     ctr, north, east;
      logic        border;
      if (frame_start) begin
        row_pos = 0;
        col_pos = 0;
      end
      rows  = clamp_dim(rows_reg);
      cols  = clamp_dim(cols_reg);
      r     = row_pos;
      c     = col_pos % GRID_MAX;
      ctr   = row_last[c];
      north = row_above[c];
      east  = (c + 1 < GRID_MAX) ? row_last[c + 1] : '0;
      if (r >= 1) begin
        orow   = r - 1;
        border = orow == 0 || orow >= rows - 1 || c == 0 || c >= cols - 1;
        due_results.push_back(result_t'{
          value: border ? ctr : diffuse_point(ctr, north, s, west, east),
          row: idx_t'(orow), col: idx_t'(c), last: 1'b0});
      end
      // the last row also leaves as itself
      if (r == rows - 1)
        due_results.push_back(result_t'{value: s, row: idx_t'(r), col: idx_t'(c),
                                         last: c == cols - 1});
      west         = ctr;
      row_above[c] = ctr;
      row_last[c]  = s;
      if (c + 1 >= cols) begin
        col_pos = 0;
        row_pos = (r + 1 >= rows) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void report(string field, longint want, longint got);
      errors++;
      $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $error("result with nothing due: value %0d row %0d col %0d",
               got.value, got.row, got.col);
        return;
      end
      want = due_results.pop_front();
      if (got.value !== want.value) report("value", want.value, got.value);
      if (got.row !== want.row) report("row_index", want.row, got.row);
      if (got.col !== want.col) report("col_index", want.col, got.col);
      if (got.last !== want.last) report("frame_end", want.last, got.last);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;   // [31:0] sample
  logic [0:0]            s_tuser = '0;   // [0] frame_start
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;        // [31:0] value, [41:32] row_index,
                                         // [51:42] col_index, [55:52] zero
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  stencil_scoreboard sb = new();

  int       cycles = 0;
  int       burst_left = 0;
  int       hold_requests = 0;
  int       hold_served = 0;
  int       hold_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;

  heat_diffusion_stencil_step_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("heat_diffusion_stencil_step_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.take_sample(sample_t'(s_tdata[SAMPLE_W-1:0]), s_tuser[0]);
      if (m_tvalid && m_tready)
        sb.check_result(result_t'{
          value: m_tdata[SAMPLE_W-1:0],
          row:   m_tdata[SAMPLE_W+IDX_W-1:SAMPLE_W],
          col:   m_tdata[SAMPLE_W+2*IDX_W-1:SAMPLE_W+IDX_W],
          last:  m_tlast});
    end
  end

  // Result side: random stall modes, plus a long hold-off on request.
  always @(posedge clk) begin
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 400);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:  m_tready <= 1'b1;
        RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
        default:  m_tready <= (rx_tick % 5 != 0);
      endcase
    end
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return sample_t'(32'h8000_0000);
          1: return sample_t'(32'h7FFF_FFFF);
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3, 4: return sample_t'($urandom);
      // plausible temperatures, -100.0 .. +100.0
      default: return sample_t'(int'($urandom_range(0, 51200)) - 25600);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 16'd6554;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim(int unsigned hi);
    case ($urandom_range(0, 9))
      0: return CFG_DATA_W'($urandom_range(0, 2));
      // upper bits lie outside the register and drop away
      1: return 16'hF800 | CFG_DATA_W'($urandom_range(3, hi));
      default: return CFG_DATA_W'($urandom_range(3, hi));
    endcase
  endfunction

  task automatic send_sample(sample_t value, logic frame_start);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= frame_start;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_DATA_W-1:0] cx, logic [CFG_DATA_W-1:0] cy,
                              logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols);
    put_reg(REG_COEF_X, cx);
    put_reg(REG_COEF_Y, cy);
    put_reg(REG_GRID_ROWS, rows);
    put_reg(REG_GRID_COLS, cols);
    cfg_we <= 1'b0;
  endtask

  // Drop valid, drain every due result, then let the pipeline empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    // 3 x 4 grid: one interior point saturates high, its neighbour low
    sample_t corner_grid [12] = '{
      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
      32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    logic [CFG_DATA_W-1:0] rows_w, cols_w, last_cols_w;
    int   items_done, phase, n_grids, grid_len, eff_rows, eff_cols;
    logic restart;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // grid_rows below the minimum clamps to three rows
    write_config('1, '1, 16'd0, 16'd4);
    for (int k = 0; k < 12; k++) send_sample(corner_grid[k], k == 0);
    settle();

    // shrink the grid under the row counter: the stray row is border, no copy
    write_config(16'd6554, 16'd13107, 16'd6, 16'd3);
    for (int k = 0; k < 9; k++) send_sample(pick_sample(), k == 0);
    settle();
    write_config(16'd6554, 16'd13107, 16'd3, 16'd3);
    for (int k = 0; k < 3; k++) send_sample(pick_sample(), 1'b0);
    settle();

    last_cols_w = 16'd3;
    items_done  = 0;
    phase       = 0;
    while (items_done < RANDOM_ITEMS) begin
      rows_w = pick_dim(10);
      cols_w = pick_dim(24);
      // a full-size grid under a long hold-off fills the block
      if (phase == 1) begin
        rows_w = 16'd10;
        cols_w = 16'd24;
      end
      write_config(pick_coef(), pick_coef(), rows_w, cols_w);
      if (phase == 1) hold_requests <= hold_requests + 1;
      eff_rows = sb.clamp_dim(rows_w[DIM_W-1:0]);
      eff_cols = sb.clamp_dim(cols_w[DIM_W-1:0]);
      // a new width needs a fresh grid so no unwritten line entry is used
      restart     = cols_w != last_cols_w;
      last_cols_w = cols_w;
      n_grids     = $urandom_range(1, 3);
      for (int g = 0; g < n_grids; g++) begin
        grid_len = eff_rows * eff_cols;
        if (phase != 1 && g == n_grids - 1 && $urandom_range(0, 3) == 0)
          grid_len = $urandom_range(1, grid_len);
        for (int k = 0; k < grid_len && items_done < RANDOM_ITEMS; k++) begin
          send_sample(pick_sample(),
                      (k == 0 && (restart || $urandom_range(0, 3) != 0)) ||
                      $urandom_range(0, 99) == 0);
          restart = 1'b0;
          items_done++;
        end
      end
      settle();
      phase++;
    end

    if (sb.errors == 0)
      $display("heat_diffusion_stencil_step_top regression: pass");
    else
      $display("heat_diffusion_stencil_step_top regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/hds_pkg.sv
hw/rtl/hds_front.sv
hw/rtl/hds_queue.sv
hw/rtl/hds_back.sv
hw/rtl/heat_diffusion_stencil_step_top.sv
tb/tb_heat_diffusion_stencil_step_top.sv
